[src/range_bucketed_key_counter_core_assert.svh]
// Assertion macros shared by the checker of the key counter core.
`ifndef RANGE_BUCKETED_KEY_COUNTER_CORE_ASSERT_SVH
`define RANGE_BUCKETED_KEY_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RBKC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key counter core: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RBKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key counter core: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define RBKC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("key counter core: reset check failed");

`endif

[src/rbkc_pkg.sv]
// Shared types and constants of the range bucketed key counter.
`timescale 1ns / 1ps

package rbkc_pkg;

   localparam int KEY_W   = 24;
   localparam int COUNT_W = 32;
   localparam int RANGE_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_DUMP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_ADD_OK     = 2'd0,
      KIND_ADD_DROP   = 2'd1,
      KIND_DUMP_ENTRY = 2'd2,
      KIND_DUMP_EMPTY = 2'd3
   } kind_type;

   typedef struct packed {
      op_type             operation;
      logic [KEY_W-1:0]   key;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [KEY_W-1:0]   entry_key;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_HIT,
      ST_MISS,
      ST_DUMP_START,
      ST_DUMP_EMPTY,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic div_step;
      logic mem_read;
      logic slot_inc;
      logic bin_next;
      logic hit_commit;
      logic miss_commit;
      logic dump_emit;
      logic dump_empty;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_dump;
      logic div_done;
      logic slot_at_fill;
      logic key_match;
      logic out_free;
      logic table_empty;
      logic last_entry;
   } status_type;

endpackage

[src/range_bucketed_key_counter_core.sv]
// Top level of the range bucketed key counter: controller plus datapath.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  req_data  (operation, key)
//  rsp_      out        rsp_valid / rsp_ready  rsp_data  (kind, entry_key, entry_count, last)
//  csr_      in         csr_valid / csr_ready  csr_data  (key_range)
//
//  Add: accept, up to BUCKETS-1 divider steps, one RAM read and one compare per scanned slot
//  of the bin, a scan-end check on a miss, then the commit, held while the output register is full.
//  Dump: one read per stored entry plus a step per bin, set by the single RAM read port.
//  Reset clears the fill counts and entry total at once; the entry RAMs need no clearing pass.
//  A stalled result holds in the output register; the next item is taken while it waits.

module range_bucketed_key_counter_core #(
   parameter int BUCKETS   = 8,
   parameter int BIN_DEPTH = 8,
   parameter int KEY_BITS  = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rbkc_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rbkc_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rbkc_pkg::RANGE_W-1:0] csr_data
);

   // Command and status between the sequencer and the datapath.
   rbkc_pkg::cmd_type    cmd;
   rbkc_pkg::status_type status;

   // Sequence the add scan and the dump walk; take a transaction only when idle.
   rbkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the range register, bin divider, fill counts, entry RAMs and the result register.
   rbkc_datapath #(
      .BUCKETS   (BUCKETS),
      .BIN_DEPTH (BIN_DEPTH),
      .KEY_BITS  (KEY_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[src/rbkc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rbkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rbkc_datapath.sv]
// Datapath of the key counter: range register, bin divider, bin fills, entry RAMs, result register.
`timescale 1ns / 1ps

module rbkc_datapath #(
   parameter int BUCKETS   = 8,
   parameter int BIN_DEPTH = 8,
   parameter int KEY_BITS  = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rbkc_pkg::req_type            req_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rbkc_pkg::RANGE_W-1:0] csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rbkc_pkg::rsp_type            rsp_data,
   input  rbkc_pkg::cmd_type            cmd,
   output rbkc_pkg::status_type         status
);

   localparam int KW      = rbkc_pkg::KEY_W;
   localparam int CW      = rbkc_pkg::COUNT_W;
   localparam int RW      = rbkc_pkg::RANGE_W;
   localparam int SKW     = (KEY_BITS < KW) ? KEY_BITS : KW;
   localparam int BIN_W   = $clog2(BUCKETS);
   localparam int STEP_W  = $clog2(BUCKETS + 1);
   localparam int ACC_W   = RW + STEP_W;
   localparam int SLOTS   = BUCKETS * BIN_DEPTH;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int FILL_W  = $clog2(BIN_DEPTH + 1);
   localparam int TOTAL_W = $clog2(SLOTS + 1);

   logic [RW-1:0]      range_ff, range_in;
   rbkc_pkg::op_type   op_ff, op_in;
   logic [SKW-1:0]     key_ff, key_in;
   logic [ACC_W-1:0]   num_ff, num_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               small_ff, small_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [FILL_W-1:0]  slot_ff, slot_in;
   logic [FILL_W-1:0]  fill_ff [BUCKETS];
   logic [FILL_W-1:0]  fill_in [BUCKETS];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] emitted_ff, emitted_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rbkc_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [SKW-1:0]     req_key;
   logic [BIN_W-1:0]   req_bin_small;
   logic [FILL_W-1:0]  cur_fill;
   logic               bin_full;
   logic [ADDR_W-1:0]  addr;
   logic [SKW-1:0]     key_rd;
   logic [CW-1:0]      count_rd;
   logic [CW-1:0]      count_new;
   logic               key_wr;
   logic               count_wr;
   logic [CW-1:0]      count_wdata;
   logic               last_entry;
   logic               clear_table;

   // Bits above KEY_BITS are dropped from the key.
   assign req_key       = req_data.key[SKW-1:0];
   assign req_bin_small = (req_key > SKW'(BUCKETS - 1)) ? BIN_W'(BUCKETS - 1)
                                                        : BIN_W'(req_key);

   assign cur_fill   = fill_ff[bin_ff];
   assign bin_full   = (cur_fill == FILL_W'(BIN_DEPTH));
   assign addr       = ADDR_W'(ADDR_W'(bin_ff) * ADDR_W'(BIN_DEPTH)) + ADDR_W'(slot_ff);
   assign count_new  = (count_rd == rbkc_pkg::COUNT_MAX) ? count_rd : count_rd + CW'(1);
   assign last_entry = (TOTAL_W'(emitted_ff + TOTAL_W'(1)) == total_ff);
   assign clear_table = cmd.dump_empty || (cmd.dump_emit && last_entry);

   assign key_wr      = cmd.miss_commit && !bin_full;
   assign count_wr    = cmd.hit_commit || key_wr;
   assign count_wdata = cmd.hit_commit ? count_new : CW'(1);

   rbkc_ram #(
      .WIDTH (SKW),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (addr),
      .wr_data (key_ff),
      .rd_en   (cmd.mem_read),
      .rd_addr (addr),
      .rd_data (key_rd)
   );

   rbkc_ram #(
      .WIDTH (CW),
      .DEPTH (SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_wr),
      .wr_addr (addr),
      .wr_data (count_wdata),
      .rd_en   (cmd.mem_read),
      .rd_addr (addr),
      .rd_data (count_rd)
   );

   always_comb begin
      range_in     = range_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      num_in       = num_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      small_in     = small_ff;
      bin_in       = bin_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      emitted_in   = emitted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         range_in = csr_data;
      end

      if (cmd.accept) begin
         op_in      = req_data.operation;
         key_in     = req_key;
         num_in     = ACC_W'(req_key) * ACC_W'(BUCKETS - 1);
         acc_in     = ACC_W'(range_ff);
         step_in    = STEP_W'(1);
         small_in   = (range_ff < RW'(BUCKETS));
         bin_in     = ((req_data.operation == rbkc_pkg::OP_ADD) && (range_ff < RW'(BUCKETS)))
                      ? req_bin_small : '0;
         slot_in    = '0;
         emitted_in = '0;
      end

      // Find the largest step whose multiple of the range stays within the numerator.
      if (cmd.div_step) begin
         bin_in  = BIN_W'(step_ff);
         acc_in  = acc_ff + ACC_W'(range_ff);
         step_in = step_ff + STEP_W'(1);
      end

      if (cmd.slot_inc) begin
         slot_in = slot_ff + FILL_W'(1);
      end

      if (cmd.bin_next) begin
         bin_in  = bin_ff + BIN_W'(1);
         slot_in = '0;
      end

      if (cmd.hit_commit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.kind        = rbkc_pkg::KIND_ADD_OK;
         rsp_data_in.entry_key   = KW'(key_ff);
         rsp_data_in.entry_count = count_new;
         rsp_data_in.last        = 1'b1;
      end

      if (cmd.miss_commit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.entry_key = KW'(key_ff);
         rsp_data_in.last      = 1'b1;
         if (bin_full) begin
            rsp_data_in.kind        = rbkc_pkg::KIND_ADD_DROP;
            rsp_data_in.entry_count = '0;
         end else begin
            rsp_data_in.kind        = rbkc_pkg::KIND_ADD_OK;
            rsp_data_in.entry_count = CW'(1);
            fill_in[bin_ff]         = cur_fill + FILL_W'(1);
            total_in                = total_ff + TOTAL_W'(1);
         end
      end

      if (cmd.dump_emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.kind        = rbkc_pkg::KIND_DUMP_ENTRY;
         rsp_data_in.entry_key   = KW'(key_rd);
         rsp_data_in.entry_count = count_rd;
         rsp_data_in.last        = last_entry;
         emitted_in              = emitted_ff + TOTAL_W'(1);
         slot_in                 = slot_ff + FILL_W'(1);
      end

      if (cmd.dump_empty) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.kind        = rbkc_pkg::KIND_DUMP_EMPTY;
         rsp_data_in.entry_key   = '0;
         rsp_data_in.entry_count = '0;
         rsp_data_in.last        = 1'b1;
      end

      if (clear_table) begin
         for (int b = 0; b < BUCKETS; b++) begin
            fill_in[b] = '0;
         end
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         range_ff     <= range_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      num_ff      <= num_in;
      acc_ff      <= acc_in;
      step_ff     <= step_in;
      small_ff    <= small_in;
      bin_ff      <= bin_in;
      slot_ff     <= slot_in;
      emitted_ff  <= emitted_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.req_dump     = (req_data.operation == rbkc_pkg::OP_DUMP);
   assign status.div_done     = small_ff || (op_ff == rbkc_pkg::OP_DUMP)
                                || (step_ff == STEP_W'(BUCKETS)) || (acc_ff > num_ff);
   assign status.slot_at_fill = (slot_ff == cur_fill);
   assign status.key_match    = (key_rd == key_ff);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.table_empty  = (total_ff == '0);
   assign status.last_entry   = last_entry;

endmodule

[src/rbkc_ctrl.sv]
// Controller state machine of the key counter.
`timescale 1ns / 1ps

module rbkc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rbkc_pkg::status_type status,
   output rbkc_pkg::cmd_type    cmd
);

   rbkc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbkc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbkc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_dump ? rbkc_pkg::ST_DUMP_START : rbkc_pkg::ST_DIV;
            end
         end
         rbkc_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = rbkc_pkg::ST_SCAN_RD;
            end
         end
         rbkc_pkg::ST_SCAN_RD: begin
            state_in = status.slot_at_fill ? rbkc_pkg::ST_MISS : rbkc_pkg::ST_SCAN_CMP;
         end
         rbkc_pkg::ST_SCAN_CMP: begin
            state_in = status.key_match ? rbkc_pkg::ST_HIT : rbkc_pkg::ST_SCAN_RD;
         end
         rbkc_pkg::ST_HIT, rbkc_pkg::ST_MISS, rbkc_pkg::ST_DUMP_EMPTY: begin
            if (status.out_free) begin
               state_in = rbkc_pkg::ST_IDLE;
            end
         end
         rbkc_pkg::ST_DUMP_START: begin
            state_in = status.table_empty ? rbkc_pkg::ST_DUMP_EMPTY : rbkc_pkg::ST_DUMP_RD;
         end
         rbkc_pkg::ST_DUMP_RD: begin
            if (!status.slot_at_fill) begin
               state_in = rbkc_pkg::ST_DUMP_OUT;
            end
         end
         rbkc_pkg::ST_DUMP_OUT: begin
            if (status.out_free) begin
               state_in = status.last_entry ? rbkc_pkg::ST_IDLE : rbkc_pkg::ST_DUMP_RD;
            end
         end
         default: begin
            state_in = rbkc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rbkc_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         rbkc_pkg::ST_DIV: begin
            cmd.div_step = !status.div_done;
         end
         rbkc_pkg::ST_SCAN_RD: begin
            cmd.mem_read = !status.slot_at_fill;
         end
         rbkc_pkg::ST_SCAN_CMP: begin
            cmd.slot_inc = !status.key_match;
         end
         rbkc_pkg::ST_HIT: begin
            cmd.hit_commit = status.out_free;
         end
         rbkc_pkg::ST_MISS: begin
            cmd.miss_commit = status.out_free;
         end
         rbkc_pkg::ST_DUMP_START: begin
         end
         rbkc_pkg::ST_DUMP_EMPTY: begin
            cmd.dump_empty = status.out_free;
         end
         rbkc_pkg::ST_DUMP_RD: begin
            cmd.bin_next = status.slot_at_fill;
            cmd.mem_read = !status.slot_at_fill;
         end
         rbkc_pkg::ST_DUMP_OUT: begin
            cmd.dump_emit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

[src/rbkc_checker.sv]
// Port-level checker for the key counter core, with its bind.
`timescale 1ns / 1ps
`include "range_bucketed_key_counter_core_assert.svh"

module rbkc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rbkc_pkg::rsp_type rsp_data
);

   `RBKC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `RBKC_ASSERT_NOW(a_add_last, clock, reset, rsp_valid && (rsp_data.kind == rbkc_pkg::KIND_ADD_OK || rsp_data.kind == rbkc_pkg::KIND_ADD_DROP), rsp_data.last)
   `RBKC_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_data.kind == rbkc_pkg::KIND_DUMP_EMPTY, rsp_data.last && rsp_data.entry_key == '0 && rsp_data.entry_count == '0)
   `RBKC_ASSERT_NOW(a_count_nonzero, clock, reset, rsp_valid && (rsp_data.kind == rbkc_pkg::KIND_ADD_OK || rsp_data.kind == rbkc_pkg::KIND_DUMP_ENTRY), rsp_data.entry_count != '0)
   `RBKC_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind range_bucketed_key_counter_core rbkc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
